>>> hw/rtl/rmfw_pkg.sv
// Shared types and constants of the recursive mutex with a waiter queue.
`default_nettype none

package rmfw_pkg;

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ACQUIRED   = 3'd0,
		ST_NESTED     = 3'd1,
		ST_QUEUED     = 3'd2,
		ST_PARTIAL    = 3'd3,
		ST_RELEASED   = 3'd4,
		ST_NOT_HOLDER = 3'd5,
		ST_QUEUE_FULL = 3'd6,
		ST_OVERFLOW   = 3'd7
	} status_t;

	typedef enum logic {
		BK_WAIT = 1'b0,
		BK_EXEC = 1'b1
	} back_state_t;

	localparam int TID_W = 8;
	localparam int DEPTH_W = 16;
	localparam int MIDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	typedef struct packed {
		cmd_t             command;
		logic [TID_W-1:0] thread_id;
	} in_item_t;

	// Request after the front end has reduced the thread id into range.
	typedef struct packed {
		cmd_t             cmd;
		logic [TID_W-1:0] tid;
	} mid_item_t;

	typedef struct packed {
		status_t            status;
		logic               woken_valid;
		logic [TID_W-1:0]   woken_thread;
		logic               owner_valid;
		logic [TID_W-1:0]   owner_thread;
		logic [DEPTH_W-1:0] nesting_depth;
	} res_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/rmfw_fifo.sv
// Small first-in first-out queue of register entries.
`default_nettype none

module rmfw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rmfw_front.sv
// Front end: takes requests, reduces the thread id and queues them for the back end.
`default_nettype none

module rmfw_front #(
	parameter int MAX_THREADS = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire rmfw_pkg::in_item_t  request,
	input  wire logic                pop,
	output logic                     empty,
	output rmfw_pkg::mid_item_t      item
);

	logic [rmfw_pkg::TID_W-1:0] tid_red;
	rmfw_pkg::mid_item_t        mid_in;

	generate
		if (MAX_THREADS < 256) begin : g_reduce
			// Remainder by multiplying with a rounded-up reciprocal; one
			// compare and subtract covers the rounding error.
			localparam logic [15:0] RECIP = 16'((65536 + MAX_THREADS - 1) / MAX_THREADS);
			localparam logic [7:0]  MODV  = 8'(MAX_THREADS);
			logic [23:0] prod;
			logic [15:0] qm;
			logic [7:0]  rem;

			always_comb begin
				prod    = {16'd0, request.thread_id} * {8'd0, RECIP};
				qm      = {8'd0, prod[23:16]} * {8'd0, MODV};
				rem     = request.thread_id - qm[7:0];
				tid_red = (rem >= MODV) ? rem - MODV : rem;
			end
		end else begin : g_pass
			assign tid_red = request.thread_id;
		end
	endgenerate

	always_comb begin
		mid_in.cmd = request.command;
		mid_in.tid = tid_red;
	end

	rmfw_fifo #(
		.WIDTH($bits(rmfw_pkg::mid_item_t)),
		.DEPTH(rmfw_pkg::MIDQ_DEPTH)
	) u_midq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (mid_in),
		.pop   (pop),
		.empty (empty),
		.dout  (item)
	);

endmodule

`default_nettype wire

>>> hw/rtl/rmfw_back.sv
// Back end: lock state, waiter queue memory and waiting map, one request at a time.
`default_nettype none

module rmfw_back #(
	parameter int MAX_THREADS = 256,
	parameter int QUEUE_DEPTH = 16,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                mid_empty,
	input  wire rmfw_pkg::mid_item_t mid_item,
	output logic                     mid_pop,
	input  wire logic                res_full,
	output logic                     res_push,
	output rmfw_pkg::res_item_t      res_item
);

	localparam int MAP_DEPTH = (MAX_THREADS < 256) ? MAX_THREADS : 256;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int QW        = $clog2(QUEUE_DEPTH);
	localparam int FCW       = $clog2(QUEUE_DEPTH + 1);
	localparam int TW        = rmfw_pkg::TID_W;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	rmfw_pkg::back_state_t state_q, state_d;

	logic                  held_q;
	logic [TW-1:0]         holder_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [QW-1:0]         head_q;
	logic [QW-1:0]         tail_q;
	logic [FCW-1:0]        fcount_q;
	logic [MAP_DEPTH-1:0]  waiting_q;
	logic [TW-1:0]         waiter_mem [QUEUE_DEPTH];

	rmfw_pkg::cmd_t        cmd_q;
	logic [TW-1:0]         tid_q;
	logic                  map_rd_q;
	logic [TW-1:0]         head_rd_q;

	logic                  held_d;
	logic [TW-1:0]         holder_d;
	logic [COUNT_BITS-1:0] count_d;
	logic                  enq;
	logic                  deq;
	rmfw_pkg::status_t     status_d;
	logic                  is_holder;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rmfw_pkg::BK_WAIT: if (!mid_empty) state_d = rmfw_pkg::BK_EXEC;
			rmfw_pkg::BK_EXEC: if (!res_full) state_d = rmfw_pkg::BK_WAIT;
			default:           state_d = rmfw_pkg::BK_WAIT;
		endcase
	end

	always_comb begin
		mid_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			rmfw_pkg::BK_WAIT: mid_pop = !mid_empty;
			rmfw_pkg::BK_EXEC: res_push = !res_full;
			default: begin
				mid_pop  = 1'b0;
				res_push = 1'b0;
			end
		endcase
	end

	always_comb begin
		held_d    = held_q;
		holder_d  = holder_q;
		count_d   = count_q;
		enq       = 1'b0;
		deq       = 1'b0;
		status_d  = rmfw_pkg::ST_NOT_HOLDER;
		is_holder = held_q && (holder_q == tid_q);
		if (cmd_q == rmfw_pkg::CMD_ACQUIRE) begin
			if (is_holder) begin
				if (count_q == CMAX) begin
					status_d = rmfw_pkg::ST_OVERFLOW;
				end else begin
					count_d  = count_q + 1'b1;
					status_d = rmfw_pkg::ST_NESTED;
				end
			end else if (!held_q) begin
				held_d   = 1'b1;
				holder_d = tid_q;
				count_d  = COUNT_BITS'(1);
				status_d = rmfw_pkg::ST_ACQUIRED;
			end else if (map_rd_q) begin
				status_d = rmfw_pkg::ST_QUEUED;
			end else if (fcount_q == FCW'(QUEUE_DEPTH)) begin
				status_d = rmfw_pkg::ST_QUEUE_FULL;
			end else begin
				enq      = 1'b1;
				status_d = rmfw_pkg::ST_QUEUED;
			end
		end else begin
			if (!is_holder) begin
				status_d = rmfw_pkg::ST_NOT_HOLDER;
			end else if (count_q > COUNT_BITS'(1)) begin
				count_d  = count_q - 1'b1;
				status_d = rmfw_pkg::ST_PARTIAL;
			end else if (fcount_q != '0) begin
				// Hand the lock straight to the oldest waiter.
				deq      = 1'b1;
				holder_d = head_rd_q;
				count_d  = COUNT_BITS'(1);
				status_d = rmfw_pkg::ST_RELEASED;
			end else begin
				held_d   = 1'b0;
				holder_d = '0;
				count_d  = '0;
				status_d = rmfw_pkg::ST_RELEASED;
			end
		end
	end

	always_comb begin
		res_item.status        = status_d;
		res_item.woken_valid   = deq;
		res_item.woken_thread  = deq ? head_rd_q : '0;
		res_item.owner_valid   = held_d;
		res_item.owner_thread  = held_d ? holder_d : '0;
		res_item.nesting_depth = held_d ? rmfw_pkg::DEPTH_W'(count_d) : '0;
	end

	// Request capture and registered reads of the map and the queue head.
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			cmd_q     <= mid_item.cmd;
			tid_q     <= mid_item.tid;
			map_rd_q  <= waiting_q[mid_item.tid[MAP_AW-1:0]];
			head_rd_q <= waiter_mem[head_q];
		end
		if (res_push && enq) begin
			waiter_mem[tail_q] <= tid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rmfw_pkg::BK_WAIT;
			held_q    <= 1'b0;
			holder_q  <= '0;
			count_q   <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fcount_q  <= '0;
			waiting_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_push) begin
				held_q   <= held_d;
				holder_q <= holder_d;
				count_q  <= count_d;
				if (enq) begin
					tail_q   <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					fcount_q <= fcount_q + 1'b1;
					waiting_q[tid_q[MAP_AW-1:0]] <= 1'b1;
				end
				if (deq) begin
					head_q   <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					fcount_q <= fcount_q - 1'b1;
					waiting_q[head_rd_q[MAP_AW-1:0]] <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/recursive_mutex_fifo_waiters.sv
// Recursive mutex with a first-in first-out queue of waiting threads.
//
// Requests enter on the push/full side as a request struct (acquire or
// release by a thread id); every request gives exactly one result on the
// empty/pop side, in request order. A result reports the status, the waiter
// that was handed the lock on a final release, and the owner and nesting
// depth after the request.
// A request passes a two-entry front queue, then the back end handles it in two
// steps: it captures the request and reads the waiting map and the queue head,
// then it updates the lock state and writes the result, waiting there while the
// result queue is full. The back end takes no new request before it has written
// the result of the last one.
// When the receiver stalls, results collect in a two-entry result queue,
// then the back end holds its current request and the front queue fills
// until full is raised. Reset frees the lock, empties both queues and the
// waiter queue and clears the waiting map at once; no clearing pass is needed.
`default_nettype none

module recursive_mutex_fifo_waiters #(
	parameter int MAX_THREADS = 256,
	parameter int QUEUE_DEPTH = 16,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire rmfw_pkg::in_item_t request,
	output logic                    empty,
	input  wire logic               pop,
	output rmfw_pkg::res_item_t     result
);

	rmfw_pkg::mid_item_t mid_item;
	rmfw_pkg::res_item_t res_item;
	logic                mid_empty;
	logic                mid_pop;
	logic                res_full;
	logic                res_push;

	rmfw_front #(
		.MAX_THREADS(MAX_THREADS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.item   (mid_item)
	);

	rmfw_back #(
		.MAX_THREADS(MAX_THREADS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.mid_item (mid_item),
		.mid_pop  (mid_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_item)
	);

	rmfw_fifo #(
		.WIDTH($bits(rmfw_pkg::res_item_t)),
		.DEPTH(rmfw_pkg::RESQ_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (res_item),
		.pop   (pop),
		.empty (empty),
		.dout  (result)
	);

endmodule

`default_nettype wire
